### design/adbt_pkg.sv
// Shared types, codes and defaults for the audio DMA double-buffer timer.
package adbt_pkg;

   // Bus command codes
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Register word offsets that have side effects or readback
   localparam logic [2:0] REG_LENGTH = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd3;

   // Classified operation kinds handed from front to back
   localparam int KIND_BITS = 3;
   localparam logic [KIND_BITS-1:0] KIND_NOP     = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_RD_LEN  = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_RD_STAT = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_WR_LEN  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_WR_STAT = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_TICK    = 3'd5;

   // Defaults and fixed values
   localparam int          MAX_LENGTH_DEFAULT = 262144;
   localparam int          TIMER_BITS_DEFAULT = 34;
   localparam int          RATE_BITS          = 16;
   localparam logic [15:0] RATE_RESET         = 16'd500;
   localparam logic [31:0] LEN_READ_MASK      = 32'hFFFF_FFF8;
   localparam int          STATUS_FULL_POS    = 31;
   localparam int          STATUS_BUSY_POS    = 30;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [31:0]          data;
      logic [31:0]          mask;
   } op_type;

   typedef struct packed {
      logic full;
      logic busy;
      logic queued;
      logic timer_idle;
   } sts_type;

endpackage

### design/adbt_front.sv
// Front end: accepts bus transactions and ticks, classifies them, queues them.
module adbt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_command,
   input  logic [2:0]            req_reg_index,
   input  logic [31:0]           req_write_data,
   input  logic [31:0]           req_write_mask,
   output logic                  op_valid,
   output adbt_pkg::op_type      op,
   input  logic                  op_pop
);

   localparam int DEPTH    = 2;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   adbt_pkg::op_type       entry_ff [DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   adbt_pkg::op_type       classified;
   logic                   push_ok;
   logic                   pop_ok;

   // Classify: address, control and rate registers have no readback path,
   // so their writes retire as no-ops
   always_comb begin
      classified.kind = adbt_pkg::KIND_NOP;
      classified.data = req_write_data;
      classified.mask = req_write_mask;
      unique case (req_command)
         adbt_pkg::CMD_READ: begin
            if (req_reg_index == adbt_pkg::REG_LENGTH) begin
               classified.kind = adbt_pkg::KIND_RD_LEN;
            end else if (req_reg_index == adbt_pkg::REG_STATUS) begin
               classified.kind = adbt_pkg::KIND_RD_STAT;
            end
         end
         adbt_pkg::CMD_WRITE: begin
            if (req_reg_index == adbt_pkg::REG_LENGTH) begin
               classified.kind = adbt_pkg::KIND_WR_LEN;
            end else if (req_reg_index == adbt_pkg::REG_STATUS) begin
               classified.kind = adbt_pkg::KIND_WR_STAT;
            end
         end
         adbt_pkg::CMD_TICK: classified.kind = adbt_pkg::KIND_TICK;
         default:            classified.kind = adbt_pkg::KIND_NOP;
      endcase
   end

   assign req_full = (count_ff == CNT_BITS'(DEPTH));
   assign op_valid = (count_ff != '0);
   assign op       = entry_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = op_pop && op_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified transaction
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

### design/adbt_back.sv
// Back end: register state, DMA countdown, span multiply, serial length divide.
module adbt_back #(
   parameter int MAX_LENGTH = adbt_pkg::MAX_LENGTH_DEFAULT,
   parameter int TIMER_BITS = adbt_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  op_valid,
   input  adbt_pkg::op_type      op,
   output logic                  op_pop,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_counts_per_byte,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [31:0]           rsp_read_data,
   output logic                  rsp_irq,
   output adbt_pkg::sts_type     sts
);

   localparam int LEN_BITS  = $clog2(MAX_LENGTH);
   localparam int RB        = adbt_pkg::RATE_BITS;
   localparam int PROD_BITS = LEN_BITS + RB;
   localparam int SAT_BITS  = (PROD_BITS > TIMER_BITS) ? PROD_BITS : TIMER_BITS;
   localparam int QW        = (TIMER_BITS > 32) ? TIMER_BITS : 32;
   localparam int CNT_BITS  = $clog2(TIMER_BITS + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_DIV   = 2'd1;
   localparam logic [1:0] S_MUL   = 2'd2;
   localparam logic [1:0] S_START = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [RB-1:0]         rate_ff;
   logic [31:0]           length_ff, length_in;
   logic                  full_ff, full_in;
   logic                  busy_ff, busy_in;
   logic                  irq_ff, irq_in;
   logic [LEN_BITS-1:0]   queued_ff, queued_in;
   logic [TIMER_BITS-1:0] countdown_ff, countdown_in;
   logic                  out_valid_ff, out_valid_in;
   logic [31:0]           out_data_ff;
   logic                  out_irq_ff;
   logic [LEN_BITS-1:0]   mul_len_ff, mul_len_in;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [TIMER_BITS-1:0] quo_ff, quo_in;
   logic [RB-1:0]         rem_ff, rem_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;

   logic [RB-1:0]         rate_eff;
   logic                  out_free;
   logic                  load;
   logic [31:0]           load_data;
   logic [31:0]           merged;
   logic [TIMER_BITS-1:0] cd_dec;
   logic [RB:0]           rem_sh;
   logic [RB+1:0]         diff;
   logic                  take;
   logic [QW-1:0]         quo_wide;
   logic [SAT_BITS-1:0]   prod_sat;
   logic                  over;

   assign rate_eff  = (rate_ff == '0) ? RB'(1) : rate_ff;
   assign out_free  = !out_valid_ff || rsp_pop;
   assign op_pop    = (state_ff == S_IDLE) && op_valid && out_free;
   assign csr_ready = 1'b1;
   assign merged    = (length_ff & ~op.mask) | (op.data & op.mask);
   assign cd_dec    = countdown_ff - 1'b1;

   // One restoring divide step per cycle
   assign rem_sh   = {rem_ff, quo_ff[TIMER_BITS-1]};
   assign diff     = {1'b0, rem_sh} - (RB+2)'(rate_eff);
   assign take     = !diff[RB+1];
   assign quo_wide = QW'({quo_ff[TIMER_BITS-2:0], take});

   // Saturate the registered span product to the timer width
   assign prod_sat = SAT_BITS'(prod_ff);
   assign over     = |(prod_sat >> TIMER_BITS);

   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      full_in      = full_ff;
      busy_in      = busy_ff;
      irq_in       = irq_ff;
      queued_in    = queued_ff;
      countdown_in = countdown_ff;
      mul_len_in   = mul_len_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      load         = 1'b0;
      load_data    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (op_pop) begin
               unique case (op.kind)
                  adbt_pkg::KIND_RD_LEN: begin
                     quo_in   = countdown_ff;
                     rem_in   = '0;
                     cnt_in   = CNT_BITS'(TIMER_BITS);
                     state_in = S_DIV;
                  end
                  adbt_pkg::KIND_RD_STAT: begin
                     load                               = 1'b1;
                     load_data[adbt_pkg::STATUS_FULL_POS] = full_ff;
                     load_data[adbt_pkg::STATUS_BUSY_POS] = busy_ff;
                  end
                  adbt_pkg::KIND_WR_STAT: begin
                     irq_in = 1'b0;
                     load   = 1'b1;
                  end
                  adbt_pkg::KIND_WR_LEN: begin
                     length_in = merged;
                     load      = 1'b1;
                     priority if (merged == '0) begin
                        // Zero length stops everything
                        countdown_in = '0;
                        queued_in    = '0;
                        full_in      = 1'b0;
                        busy_in      = 1'b0;
                     end else if (merged >= 32'(MAX_LENGTH)) begin
                        // Out of range: keep the merged word only
                     end else if (queued_ff != '0) begin
                        busy_in = 1'b1;
                     end else if (countdown_ff == '0) begin
                        busy_in    = 1'b1;
                        mul_len_in = merged[LEN_BITS-1:0];
                        load       = 1'b0;
                        state_in   = S_MUL;
                     end else begin
                        busy_in   = 1'b1;
                        queued_in = merged[LEN_BITS-1:0];
                        full_in   = 1'b1;
                     end
                  end
                  adbt_pkg::KIND_TICK: begin
                     load = 1'b1;
                     if (countdown_ff != '0) begin
                        countdown_in = cd_dec;
                        if (cd_dec == '0) begin
                           // Buffer expired: interrupt, start any queued buffer
                           full_in = 1'b0;
                           irq_in  = 1'b1;
                           if (queued_ff != '0) begin
                              mul_len_in = queued_ff;
                              queued_in  = '0;
                              load       = 1'b0;
                              state_in   = S_MUL;
                           end else begin
                              busy_in = 1'b0;
                           end
                        end
                     end
                  end
                  default: load = 1'b1;
               endcase
            end
         end
         S_DIV: begin
            quo_in = {quo_ff[TIMER_BITS-2:0], take};
            rem_in = take ? diff[RB-1:0] : rem_sh[RB-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               load      = 1'b1;
               load_data = quo_wide[31:0] & adbt_pkg::LEN_READ_MASK;
               state_in  = S_IDLE;
            end
         end
         S_MUL: state_in = S_START;
         S_START: begin
            countdown_in = over ? '1 : TIMER_BITS'(prod_sat);
            load         = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign out_valid_in = load ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rate_ff      <= adbt_pkg::RATE_RESET;
         length_ff    <= '0;
         full_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         irq_ff       <= 1'b0;
         queued_ff    <= '0;
         countdown_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         full_ff      <= full_in;
         busy_ff      <= busy_in;
         irq_ff       <= irq_in;
         queued_ff    <= queued_in;
         countdown_ff <= countdown_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            rate_ff <= csr_counts_per_byte;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mul_len_ff <= mul_len_in;
      prod_ff    <= PROD_BITS'(mul_len_ff) * PROD_BITS'(rate_eff);
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      if (load) begin
         out_data_ff <= load_data;
         out_irq_ff  <= irq_in;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_read_data = out_data_ff;
   assign rsp_irq       = out_irq_ff;

   assign sts.full       = full_ff;
   assign sts.busy       = busy_ff;
   assign sts.queued     = (queued_ff != '0);
   assign sts.timer_idle = (countdown_ff == '0);

endmodule

### design/audio_dma_double_buffer_timer.sv
// Audio interface register block with a two-deep DMA length queue: bus reads,
// masked bus writes and timer ticks enter a two-entry queue through push/full
// and one result per transaction leaves through empty/pop. The front stage
// takes a transaction each cycle while the queue has room. The back stage
// retires most transactions straight from idle; a length write that starts
// the timer and a tick that expires into a queued buffer pass through a
// registered span multiply and then a load, and a length read waits on the
// one-bit-per-cycle restoring divider that converts the remaining ticks to
// bytes. A finished result waits in an output register; the back stage
// takes the next transaction only once that register is empty or is being
// popped in the same cycle.
// counts_per_byte is written through the csr channel, which is always ready.
module audio_dma_double_buffer_timer #(
   parameter int MAX_LENGTH = adbt_pkg::MAX_LENGTH_DEFAULT,
   parameter int TIMER_BITS = adbt_pkg::TIMER_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   input  logic [31:0] req_write_mask,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_counts_per_byte
);

   logic              op_valid;
   adbt_pkg::op_type  op;
   logic              op_pop;
   adbt_pkg::sts_type sts;

   adbt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_command    (req_command),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .req_write_mask (req_write_mask),
      .op_valid       (op_valid),
      .op             (op),
      .op_pop         (op_pop)
   );

   adbt_back #(
      .MAX_LENGTH (MAX_LENGTH),
      .TIMER_BITS (TIMER_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .op_valid            (op_valid),
      .op                  (op),
      .op_pop              (op_pop),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_counts_per_byte (csr_counts_per_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_read_data       (rsp_read_data),
      .rsp_irq             (rsp_irq),
      .sts                 (sts)
   );

`ifndef SYNTHESIS
   // A queued second buffer always means the DMA is busy
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      sts.full |-> sts.busy)
      else $error("queue full while DMA not busy");

   // Full flag tracks the queued length
   a_full_queued: assert property (@(posedge clock) disable iff (reset)
      sts.full == sts.queued)
      else $error("full flag and queued length disagree");

   // A buffer is only queued behind a running countdown
   a_queued_timer: assert property (@(posedge clock) disable iff (reset)
      sts.queued |-> !sts.timer_idle)
      else $error("buffer queued while timer idle");
`endif

endmodule

### sim/audio_dma_regs_checker.sv
// Register codes for the audio DMA testbench and the checker that predicts and compares responses.
package adbt_tb_pkg;

   // Command with no defined meaning: the block returns zero and changes nothing
   localparam logic [1:0] CMD_NONE = 2'd3;

   // Register word offsets not named in the design package
   localparam logic [2:0] REG_ADDRESS  = 3'd0;
   localparam logic [2:0] REG_CONTROL  = 3'd2;
   localparam logic [2:0] REG_DACRATE  = 3'd4;
   localparam logic [2:0] REG_BITRATE  = 3'd5;
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

endpackage

module audio_dma_regs_checker
   import adbt_pkg::*;
   import adbt_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   input  logic [31:0] req_write_mask,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [31:0] rsp_read_data,
   input  logic        rsp_irq,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_counts_per_byte,
   output int          fail_count,
   output int          due_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                 CD_BITS = TIMER_BITS_DEFAULT;
   localparam logic [CD_BITS-1:0] CD_MAX  = '1;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq;
   } bus_rsp_type;

   // Responses owed by the block, oldest first
   bus_rsp_type due_results[$];

   // Shadow copy of the register block
   logic [15:0]        rate_cfg;
   logic [31:0]        dram_address;
   logic [31:0]        length_word;
   logic [31:0]        dac_rate;
   logic [31:0]        bit_rate;
   logic               control_bit;
   logic               fifo_full;
   logic               dma_busy;
   logic               irq_pending;
   logic [17:0]        queued_length;
   logic [CD_BITS-1:0] countdown;

   // A programmed rate of zero counts as one tick per byte
   function automatic logic [16:0] effective_rate();
      return (rate_cfg == '0) ? 17'd1 : {1'b0, rate_cfg};
   endfunction

   function automatic logic [31:0] merge_lanes(input logic [31:0] old_val,
                                               input logic [31:0] data,
                                               input logic [31:0] mask);
      return (old_val & ~mask) | (data & mask);
   endfunction

   // Ticks for one buffer, saturated at the timer width
   function automatic logic [CD_BITS-1:0] span_ticks(input logic [31:0] len);
      logic [63:0] prod;
      prod = 64'(len) * 64'(effective_rate());
      return (prod > 64'(CD_MAX)) ? CD_MAX : prod[CD_BITS-1:0];
   endfunction

   // Start the timer, queue a second buffer, or stop everything on zero
   task automatic load_length();
      if (length_word == '0) begin
         countdown     = '0;
         queued_length = '0;
         fifo_full     = 1'b0;
         dma_busy      = 1'b0;
      end else if (length_word < 32'(MAX_LENGTH_DEFAULT)) begin
         dma_busy = 1'b1;
         if (queued_length == '0) begin
            if (countdown == '0) begin
               countdown = span_ticks(length_word);
            end else begin
               queued_length = length_word[17:0];
               fifo_full     = 1'b1;
            end
         end
      end
   endtask

   // Advance the timer; on expiry raise the interrupt and start the queued buffer
   task automatic count_tick();
      if (countdown != '0) begin
         countdown = countdown - 1'b1;
         if (countdown == '0) begin
            fifo_full   = 1'b0;
            irq_pending = 1'b1;
            if (queued_length != '0) begin
               countdown     = span_ticks(32'(queued_length));
               queued_length = '0;
            end else begin
               dma_busy = 1'b0;
            end
         end
      end
   endtask

   // Apply one bus transaction to the shadow and queue the response it owes
   task automatic apply_bus_item(input logic [1:0] cmd, input logic [2:0] idx,
                                 input logic [31:0] data, input logic [31:0] mask);
      bus_rsp_type        exp_rsp;
      logic [CD_BITS-1:0] bytes_left;
      exp_rsp.read_data = '0;
      case (cmd)
         CMD_READ: begin
            if (idx == REG_LENGTH) begin
               bytes_left = countdown / CD_BITS'(effective_rate());
               exp_rsp.read_data = bytes_left[31:0] & LEN_READ_MASK;
            end else if (idx == REG_STATUS) begin
               exp_rsp.read_data[STATUS_FULL_POS] = fifo_full;
               exp_rsp.read_data[STATUS_BUSY_POS] = dma_busy;
            end
         end
         CMD_WRITE: begin
            case (idx)
               REG_ADDRESS: dram_address = merge_lanes(dram_address, data, mask);
               REG_LENGTH: begin
                  length_word = merge_lanes(length_word, data, mask);
                  load_length();
               end
               REG_CONTROL: control_bit = data[0] & mask[0];
               REG_STATUS:  irq_pending = 1'b0;
               REG_DACRATE: dac_rate = merge_lanes(dac_rate, data, mask);
               REG_BITRATE: bit_rate = merge_lanes(bit_rate, data, mask);
               default: ;
            endcase
         end
         CMD_TICK: count_tick();
         default: ;
      endcase
      exp_rsp.irq = irq_pending;
      due_results.push_back(exp_rsp);
   endtask

   always @(posedge clock) begin
      bus_rsp_type got;
      if (reset) begin
         rate_cfg      = RATE_RESET;
         dram_address  = '0;
         length_word   = '0;
         dac_rate      = '0;
         bit_rate      = '0;
         control_bit   = 1'b0;
         fifo_full     = 1'b0;
         dma_busy      = 1'b0;
         irq_pending   = 1'b0;
         queued_length = '0;
         countdown     = '0;
         due_results.delete();
      end else begin
         // Compare first: a response never belongs to a request taken at the same edge
         if (rsp_pop && !rsp_empty) begin
            if (due_results.size() == 0) begin
               $error("response with nothing owed: read_data %h irq %b",
                      rsp_read_data, rsp_irq);
               fail_count++;
            end else begin
               got = due_results.pop_front();
               if (rsp_read_data !== got.read_data) begin
                  $error("read_data mismatch: expected %h, got %h",
                         got.read_data, rsp_read_data);
                  fail_count++;
               end
               if (rsp_irq !== got.irq) begin
                  $error("irq mismatch: expected %b, got %b", got.irq, rsp_irq);
                  fail_count++;
               end
            end
         end
         if (req_push && !req_full)
            apply_bus_item(req_command, req_reg_index, req_write_data, req_write_mask);
         if (csr_valid && csr_ready)
            rate_cfg = csr_counts_per_byte;
      end
      due_count <= due_results.size();
   end

endmodule

### sim/audio_dma_double_buffer_timer_tb.sv
// Stimulus, clock, reset and verdict for the audio DMA double-buffer timer block.
module audio_dma_double_buffer_timer_tb
   import adbt_pkg::*;
   import adbt_tb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT    = 4000;
   localparam int END_SETTLE     = 60;
   localparam int PHASES         = 6;
   localparam int ITEMS_PER_PHASE = 125;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_command = CMD_READ;
   logic [2:0]  req_reg_index = '0;
   logic [31:0] req_write_data = '0;
   logic [31:0] req_write_mask = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_irq;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_counts_per_byte = '0;

   int fail_count;
   int due_count;
   int send_idle_pct = 9;
   int recv_idle_pct = 80;
   int stall_cycles = 0;
   logic [15:0] rate_plan [0:PHASES-1];

   audio_dma_double_buffer_timer u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_command         (req_command),
      .req_reg_index       (req_reg_index),
      .req_write_data      (req_write_data),
      .req_write_mask      (req_write_mask),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_read_data       (rsp_read_data),
      .rsp_irq             (rsp_irq),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_counts_per_byte (csr_counts_per_byte)
   );

   audio_dma_regs_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_command         (req_command),
      .req_reg_index       (req_reg_index),
      .req_write_data      (req_write_data),
      .req_write_mask      (req_write_mask),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_read_data       (rsp_read_data),
      .rsp_irq             (rsp_irq),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_counts_per_byte (csr_counts_per_byte),
      .fail_count          (fail_count),
      .due_count           (due_count)
   );

   initial forever #1 clock = ~clock;

   // Drain side: pop at random, never lowered and raised within one step
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Abort when no transaction moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one transaction after a random gap and hold it until taken
   task automatic send_bus(input logic [1:0] cmd, input logic [2:0] idx,
                           input logic [31:0] data, input logic [31:0] mask);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_command    <= cmd;
      req_reg_index  <= idx;
      req_write_data <= data;
      req_write_mask <= mask;
      do @(posedge clock); while (req_full);
   endtask

   // Hold off the sender until every owed response has been popped
   task automatic drain_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
   endtask

   // Program counts per byte while the block is idle
   task automatic set_rate(input logic [15:0] rate);
      drain_results();
      csr_valid           <= 1'b1;
      csr_counts_per_byte <= rate;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed DMA traffic: short buffers and ticks so the timer expires often
   task automatic send_random_item();
      int          pick;
      logic [1:0]  cmd;
      logic [2:0]  idx;
      logic [31:0] data;
      logic [31:0] mask;
      pick = $urandom_range(0, 99);
      cmd  = CMD_WRITE;
      idx  = REG_LENGTH;
      data = $urandom;
      mask = '1;
      if (pick < 34) begin
         cmd = CMD_TICK;
      end else if (pick < 48) begin
         cmd = CMD_READ;
      end else if (pick < 56) begin
         cmd = CMD_READ;
         idx = REG_STATUS;
      end else if (pick < 70) begin
         data = $urandom_range(1, 6);
      end else if (pick < 73) begin
         data = '0;
      end else if (pick < 76) begin
         data = $urandom_range(0, 7);
         mask = $urandom;
      end else if (pick < 78) begin
         data = $urandom_range(32'h1000, 32'h3FFFF);
      end else if (pick < 80) begin
         data = data | 32'(MAX_LENGTH_DEFAULT);
      end else if (pick < 84) begin
         idx  = REG_STATUS;
         mask = $urandom;
      end else if (pick < 92) begin
         case ($urandom_range(0, 3))
            0: idx = REG_ADDRESS;
            1: idx = REG_CONTROL;
            2: idx = REG_DACRATE;
            default: idx = REG_BITRATE;
         endcase
         mask = $urandom;
      end else begin
         cmd  = 2'($urandom_range(0, 3));
         idx  = 3'($urandom_range(0, 7));
         mask = $urandom;
      end
      send_bus(cmd, idx, data, mask);
   endtask

   initial begin
      rate_plan = '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd3, 16'd1};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle readback, oversize and zero lengths, longest buffer, queueing
      send_bus(CMD_READ, REG_LENGTH, '0, '0);
      send_bus(CMD_READ, REG_STATUS, '0, '0);
      send_bus(CMD_WRITE, REG_LENGTH, '1, '1);
      send_bus(CMD_WRITE, REG_LENGTH, '0, '1);
      send_bus(CMD_WRITE, REG_LENGTH, 32'h0003_FFFF, '1);
      send_bus(CMD_READ, REG_LENGTH, '0, '0);
      send_bus(CMD_WRITE, REG_LENGTH, 32'd8, 32'h0000_00FF);
      send_bus(CMD_WRITE, REG_LENGTH, 32'd16, 32'h0000_00FF);
      send_bus(CMD_READ, REG_STATUS, '0, '0);
      send_bus(CMD_TICK, REG_LENGTH, '0, '0);
      send_bus(CMD_READ, REG_LENGTH, '0, '0);
      send_bus(CMD_WRITE, REG_CONTROL, '1, '1);
      send_bus(CMD_WRITE, REG_SPARE_HI, '1, '1);
      send_bus(CMD_READ, REG_SPARE_LO, '0, '0);
      send_bus(CMD_NONE, REG_LENGTH, '1, '1);
      send_bus(CMD_WRITE, REG_LENGTH, '0, '1);

      // Directed: expiry into the queued buffer, then expiry to idle
      set_rate(16'd1);
      send_bus(CMD_WRITE, REG_LENGTH, 32'd2, '1);
      send_bus(CMD_WRITE, REG_LENGTH, 32'd3, '1);
      repeat (2) send_bus(CMD_TICK, REG_LENGTH, '0, '0);
      send_bus(CMD_READ, REG_STATUS, '0, '0);
      repeat (3) send_bus(CMD_TICK, REG_LENGTH, '0, '0);
      send_bus(CMD_WRITE, REG_STATUS, '0, '0);
      send_bus(CMD_TICK, REG_LENGTH, '0, '0);

      // Random phases: slow drain, then slow source, then full rate
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph / 2)
            0: begin send_idle_pct = 9;  recv_idle_pct = 80; end
            1: begin send_idle_pct = 80; recv_idle_pct = 9;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         set_rate(rate_plan[ph]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == ITEMS_PER_PHASE / 2)
               drain_results();
            send_random_item();
         end
      end

      drain_results();
      repeat (END_SETTLE) @(posedge clock);
      if (fail_count == 0 && due_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
